// ===== rtl/dmrpc_pkg.sv =====
package dmrpc_pkg;

  typedef struct packed {
    logic signed [31:0] left_dist;
    logic signed [31:0] right_dist;
  } in_word_t;

  typedef struct packed {
    logic        right_forward;
    logic [9:0]  right_pwm;
    logic        left_forward;
    logic [9:0]  left_pwm;
    logic        moving;
    logic [3:0]  step_index;
    logic [15:0] moves_done;
  } out_word_t;

  // configuration register indexes
  localparam logic [2:0] CFG_MARGIN   = 3'd0;
  localparam logic [2:0] CFG_INTERVAL = 3'd1;
  localparam logic [2:0] CFG_GAIN_DIV = 3'd2;
  localparam logic [2:0] CFG_BASE_PWM = 3'd3;
  localparam logic [2:0] CFG_PAUSE    = 3'd4;

  localparam logic [15:0] MARGIN_RST   = 16'd500;
  localparam logic [9:0]  INTERVAL_RST = 10'd50;
  localparam logic [7:0]  GAIN_DIV_RST = 8'd20;
  localparam logic [9:0]  BASE_PWM_RST = 10'd200;
  localparam logic [9:0]  PAUSE_RST    = 10'd50;

  // move table, entries past the eighth are zero steps
  localparam logic signed [31:0] LEFT_STEPS [16] = '{
    32'sd41000, 32'sd30000, 32'sd41000, 32'sd15000,
    32'sd58200, 32'sd15000, 32'sd41000, -32'sd30000,
    32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam logic signed [31:0] RIGHT_STEPS [16] = '{
    32'sd41000, -32'sd30000, 32'sd41000, -32'sd15000,
    32'sd58200, -32'sd15000, 32'sd41000, 32'sd30000,
    32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};

endpackage

// ===== rtl/dual_motor_ratio_position_controller_core.sv =====
// Dual wheel ratio position controller.
// in_word carries both encoder distances for one millisecond tick; every
// accepted word yields exactly one out_word with both wheel drives, the
// moving flag, the table step reached and the completed move count.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, writes belong to idle periods.
// One word is handled at a time: in_stall stays high from acceptance until
// the result is loaded into the output register. All long arithmetic runs
// through one restoring divider producing one quotient bit a cycle, with
// DIVW = DIST_WIDTH + 19 quotient bits (51 at the defaults). A plain tick
// passes error, magnitude, decision, drive and output steps; a tick that
// starts a move adds two divisions for the ratios, and a trim tick adds
// two travel scalings, mismatch, numerator and a power division. The next
// word is taken in the cycle after the result is loaded.
// The output register lets the next word be taken while a result waits;
// a stalled result holds and the sequencer waits at its final step.
// Synchronous reset restores the register defaults, clears targets, counts
// and ratios and sets left power to 200.
module dual_motor_ratio_position_controller_core import dmrpc_pkg::*; #(
  parameter int SEQ_LEN    = 10,
  parameter int DIST_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DW   = DIST_WIDTH;
  localparam int EW   = DW + 1;
  localparam int TW   = DW + 18;
  localparam int DIVW = DW + 19;
  localparam int SPW  = $clog2(SEQ_LEN + 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_ERR  = 13'b0000000000010,
    S_MAG  = 13'b0000000000100,
    S_DEC  = 13'b0000000001000,
    S_RL   = 13'b0000000010000,
    S_RR   = 13'b0000000100000,
    S_DRV  = 13'b0000001000000,
    S_TL   = 13'b0000010000000,
    S_TR   = 13'b0000100000000,
    S_MIS  = 13'b0001000000000,
    S_NUM  = 13'b0010000000000,
    S_NP   = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [15:0] margin;
  logic [9:0]  interval;
  logic [7:0]  gain_div;
  logic [9:0]  base_pwm;
  logic [9:0]  pause_ticks;

  logic signed [DW-1:0] left_target, right_target;
  logic signed [DW-1:0] ld, rd;
  logic signed [DW-1:0] left_snap, right_snap;
  logic signed [EW-1:0] el, er;
  logic [EW-1:0]        al, ar, big;
  logic [16:0]          left_ratio, right_ratio;
  logic [9:0]           left_power;
  logic [9:0]           interval_count, pause_count;
  logic [15:0]          move_count;
  logic [SPW-1:0]       step_pos;
  logic                 in_move;
  logic signed [TW-1:0]   tl, tr;
  logic signed [TW:0]     mis;
  logic signed [TW+1:0]   num;
  logic signed [TW+1:0]   num_next;
  out_word_t            res;
  logic                 out_load;

  logic                 div_start, div_done;
  logic [DIVW-1:0]      div_dividend, div_quo;
  logic [EW-1:0]        div_divisor;

  logic                 in_margin;
  logic [7:0]           kd;
  logic [9:0]           iv;
  logic [10:0]          ic_inc;
  logic signed [EW-1:0] trav_l, trav_r;
  logic [EW-1:0]        mag_l, mag_r;
  logic [26:0]          rp_prod, lp_prod;
  logic [17:0]          power_scaled;
  logic [3:0]           k;
  logic signed [TW-1:0] q_signed;

  dmrpc_div #(.DIVW(DIVW), .DSRW(EW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    in_margin    = (al <= EW'(margin)) && (ar <= EW'(margin));
    kd           = (gain_div == 8'd0) ? 8'd1 : gain_div;
    iv           = (interval == 10'd0) ? 10'd1 : interval;
    ic_inc       = {1'b0, interval_count} + 11'd1;
    trav_l       = EW'(ld) - EW'(left_snap);
    trav_r       = EW'(rd) - EW'(right_snap);
    mag_l        = trav_l[EW-1] ? EW'(-trav_l) : EW'(trav_l);
    mag_r        = trav_r[EW-1] ? EW'(-trav_r) : EW'(trav_r);
    rp_prod      = 27'(base_pwm) * 27'(right_ratio);
    lp_prod      = 27'(left_power) * 27'(left_ratio);
    power_scaled = 18'(left_power) * 18'(kd);
    k            = 4'(step_pos);
    q_signed     = TW'(div_quo[DW+16:0]);
    if (el[EW-1]) begin
      num_next = (TW+2)'(signed'({1'b0, power_scaled})) + (TW+2)'(mis);
    end else begin
      num_next = (TW+2)'(signed'({1'b0, power_scaled})) - (TW+2)'(mis);
    end
  end

  // divider issue
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_DEC: begin
        if (!in_move && !in_margin) begin
          div_start    = 1'b1;
          div_dividend = DIVW'({al, 16'd0});
          div_divisor  = (al > ar) ? al : ((ar == '0) ? EW'(1) : ar);
        end
      end
      S_RL: begin
        div_start    = div_done;
        div_dividend = DIVW'({ar, 16'd0});
        div_divisor  = big;
      end
      S_DRV: begin
        if (in_move && ic_inc >= 11'(iv) && left_ratio != '0 && right_ratio != '0) begin
          div_start    = 1'b1;
          div_dividend = DIVW'({mag_l, 16'd0});
          div_divisor  = EW'(left_ratio);
        end
      end
      S_TL: begin
        div_start    = div_done;
        div_dividend = DIVW'({mag_r, 16'd0});
        div_divisor  = EW'(right_ratio);
      end
      S_NUM: begin
        if (!num_next[TW+1]) begin
          div_start    = 1'b1;
          div_dividend = DIVW'(num_next);
          div_divisor  = EW'(kd);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      margin      <= MARGIN_RST;
      interval    <= INTERVAL_RST;
      gain_div    <= GAIN_DIV_RST;
      base_pwm    <= BASE_PWM_RST;
      pause_ticks <= PAUSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MARGIN:   margin      <= cfg_data;
        CFG_INTERVAL: interval    <= cfg_data[9:0];
        CFG_GAIN_DIV: gain_div    <= cfg_data[7:0];
        CFG_BASE_PWM: base_pwm    <= cfg_data[9:0];
        CFG_PAUSE:    pause_ticks <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      left_target    <= '0;
      right_target   <= '0;
      left_snap      <= '0;
      right_snap     <= '0;
      left_ratio     <= '0;
      right_ratio    <= '0;
      left_power     <= 10'd200;
      interval_count <= '0;
      pause_count    <= '0;
      move_count     <= '0;
      step_pos       <= '0;
      in_move        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ld    <= in_word.left_dist[DW-1:0];
            rd    <= in_word.right_dist[DW-1:0];
            state <= S_ERR;
          end
        end
        S_ERR: begin
          el    <= EW'(left_target) - EW'(ld);
          er    <= EW'(right_target) - EW'(rd);
          state <= S_MAG;
        end
        S_MAG: begin
          al    <= el[EW-1] ? EW'(-el) : EW'(el);
          ar    <= er[EW-1] ? EW'(-er) : EW'(er);
          state <= S_DEC;
        end
        S_DEC: begin
          state <= S_DRV;
          if (!in_move && !in_margin) begin
            big            <= div_divisor;
            left_snap      <= ld;
            right_snap     <= rd;
            interval_count <= '0;
            pause_count    <= '0;
            in_move        <= 1'b1;
            state          <= S_RL;
          end else if (in_move && in_margin) begin
            in_move    <= 1'b0;
            move_count <= move_count + 16'd1;
          end else if (!in_move) begin
            if (32'(step_pos) < SEQ_LEN) begin
              if (pause_count >= pause_ticks) begin
                left_target  <= left_target + LEFT_STEPS[k][DW-1:0];
                right_target <= right_target + RIGHT_STEPS[k][DW-1:0];
                step_pos     <= step_pos + 1'b1;
                pause_count  <= '0;
              end else begin
                pause_count <= pause_count + 10'd1;
              end
            end
          end
        end
        S_RL: begin
          if (div_done) begin
            left_ratio <= div_quo[16:0];
            state      <= S_RR;
          end
        end
        S_RR: begin
          if (div_done) begin
            right_ratio <= div_quo[16:0];
            state       <= S_DRV;
          end
        end
        S_DRV: begin
          res.moving     <= in_move;
          res.step_index <= 4'(step_pos);
          res.moves_done <= move_count;
          state          <= S_OUT;
          if (in_move) begin
            res.right_forward <= !er[EW-1];
            res.left_forward  <= !el[EW-1];
            res.right_pwm     <= rp_prod[25:16];
            res.left_pwm      <= lp_prod[25:16];
            if (ic_inc >= 11'(iv)) begin
              interval_count <= '0;
              if (div_start) begin
                state <= S_TL;
              end
            end else begin
              interval_count <= ic_inc[9:0];
            end
          end else begin
            res.right_forward <= 1'b1;
            res.left_forward  <= 1'b1;
            res.right_pwm     <= '0;
            res.left_pwm      <= '0;
          end
        end
        S_TL: begin
          if (div_done) begin
            tl    <= trav_l[EW-1] ? -q_signed : q_signed;
            state <= S_TR;
          end
        end
        S_TR: begin
          if (div_done) begin
            tr    <= trav_r[EW-1] ? -q_signed : q_signed;
            state <= S_MIS;
          end
        end
        S_MIS: begin
          // opposite error signs: travels add up
          if (er[EW-1] == el[EW-1]) begin
            mis <= (TW+1)'(tl) - (TW+1)'(tr);
          end else begin
            mis <= (TW+1)'(tl) + (TW+1)'(tr);
          end
          state <= S_NUM;
        end
        S_NUM: begin
          num   <= num_next;
          state <= S_NP;
        end
        S_NP: begin
          // negative numerator truncates to at most zero: clamp
          if (num[TW+1]) begin
            left_power <= '0;
            left_snap  <= ld;
            right_snap <= rd;
            state      <= S_OUT;
          end else if (div_done) begin
            left_power <= (div_quo > DIVW'(1023)) ? 10'd1023 : div_quo[9:0];
            left_snap  <= ld;
            right_snap <= rd;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= res;
    end
  end

endmodule

// ===== rtl/dmrpc_div.sv =====
module dmrpc_div import dmrpc_pkg::*; #(
  parameter int DIVW = 51,
  parameter int DSRW = 33
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DIVW-1:0] dividend,
  input  logic [DSRW-1:0] divisor,
  output logic            done,
  output logic [DIVW-1:0] quotient
);

  localparam int CW = $clog2(DIVW + 1);

  logic [DSRW-1:0] rem;
  logic [DSRW-1:0] dsr;
  logic [DIVW-1:0] quo;
  logic [CW-1:0]   count;
  logic            busy;
  logic [DSRW:0]   shifted;
  logic [DSRW:0]   trial;
  logic            fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    shifted = {rem, quo[DIVW-1]};
    trial   = shifted - {1'b0, dsr};
    fits    = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DIVW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial[DSRW-1:0] : shifted[DSRW-1:0];
      quo <= {quo[DIVW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== test/dmrpc_checker.sv =====
`timescale 1ns / 1ps

module dmrpc_checker import dmrpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          words_checked,
  output int          moves_seen,
  output longint      left_goal,
  output longint      right_goal,
  output int          step_now
);

  // register copies
  longint margin_r, interval_r, gain_r, base_r, pause_r;

  // controller state
  longint snap_l, snap_r, ratio_l, ratio_r, power_l;
  bit     in_move;
  bit     was_moving;
  int     tick_cnt, pause_cnt;
  logic [15:0] move_cnt;

  out_word_t drive_q[$];

  function automatic longint wrap_dist(longint v);
    int t;
    t = int'(v);
    return longint'(t);
  endfunction

  function automatic out_word_t next_drive(in_word_t w);
    longint ld, rd, el, er, al, ar, big, iv, kd, tl, tr, mis, num, np;
    bit in_margin;
    out_word_t r;
    ld = longint'(w.left_dist);
    rd = longint'(w.right_dist);
    el = left_goal - ld;
    er = right_goal - rd;
    al = (el < 0) ? -el : el;
    ar = (er < 0) ? -er : er;
    in_margin = (al <= margin_r) && (ar <= margin_r);
    r = '0;
    r.right_forward = 1'b1;
    r.left_forward  = 1'b1;

    if (!in_move && !in_margin) begin
      big = (al > ar) ? al : ar;
      if (big == 0) big = 1;
      ratio_l = (al << 16) / big;
      ratio_r = (ar << 16) / big;
      snap_l = ld;
      snap_r = rd;
      tick_cnt = 0;
      pause_cnt = 0;
      in_move = 1'b1;
    end else if (in_move && in_margin) begin
      in_move = 1'b0;
      move_cnt = move_cnt + 16'd1;
    end else if (!in_move && step_now < 10) begin
      if (pause_cnt >= pause_r) begin
        left_goal  = wrap_dist(left_goal + longint'(LEFT_STEPS[step_now]));
        right_goal = wrap_dist(right_goal + longint'(RIGHT_STEPS[step_now]));
        step_now++;
        pause_cnt = 0;
      end else begin
        pause_cnt = (pause_cnt + 1) & 1023;
      end
    end

    if (in_move) begin
      iv = (interval_r != 0) ? interval_r : 1;
      r.right_forward = (er >= 0);
      r.left_forward  = (el >= 0);
      r.right_pwm = 10'((base_r * ratio_r) >> 16);
      r.left_pwm  = 10'((power_l * ratio_l) >> 16);
      tick_cnt++;
      if (tick_cnt >= iv) begin
        tick_cnt = 0;
        if (ratio_l != 0 && ratio_r != 0) begin
          kd = (gain_r != 0) ? gain_r : 1;
          tl = ((ld - snap_l) * 65536) / ratio_l;
          tr = ((rd - snap_r) * 65536) / ratio_r;
          mis = ((er >= 0) == (el >= 0)) ? tl - tr : tl + tr;
          num = (el >= 0) ? power_l * kd - mis : power_l * kd + mis;
          np = num / kd;
          if (np < 0) np = 0;
          if (np > 1023) np = 1023;
          power_l = np;
          snap_l = ld;
          snap_r = rd;
        end
      end
    end
    r.moving     = in_move;
    r.step_index = 4'(step_now);
    r.moves_done = move_cnt;
    return r;
  endfunction

  assign pending = drive_q.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      margin_r = 500; interval_r = 50; gain_r = 20; base_r = 200; pause_r = 50;
      left_goal = 0; right_goal = 0; step_now = 0; in_move = 0;
      snap_l = 0; snap_r = 0; ratio_l = 0; ratio_r = 0; power_l = 200;
      tick_cnt = 0; pause_cnt = 0; move_cnt = '0;
      was_moving = 0;
      drive_q.delete();
      fails = 0; words_checked = 0; moves_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MARGIN:   margin_r   = cfg_data;
          CFG_INTERVAL: interval_r = cfg_data[9:0];
          CFG_GAIN_DIV: gain_r     = cfg_data[7:0];
          CFG_BASE_PWM: base_r     = cfg_data[9:0];
          CFG_PAUSE:    pause_r    = cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: unexpected output word %p", $realtime, out_word);
        end else begin
          exp_w = drive_q.pop_front();
          words_checked++;
          if (was_moving && !exp_w.moving) moves_seen++;
          was_moving = exp_w.moving;
          if (out_word.right_forward !== exp_w.right_forward ||
              out_word.right_pwm !== exp_w.right_pwm ||
              out_word.left_forward !== exp_w.left_forward ||
              out_word.left_pwm !== exp_w.left_pwm ||
              out_word.moving !== exp_w.moving ||
              out_word.step_index !== exp_w.step_index ||
              out_word.moves_done !== exp_w.moves_done) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch word %0d\n  exp %p\n  got %p",
                       $realtime, words_checked, exp_w, out_word);
          end
        end
      end
      if (in_valid && !in_stall) drive_q.push_back(next_drive(in_word));
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb import dmrpc_pkg::*;;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_word_t    in_word;
  out_word_t   out_word;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int     fails, pending, words_checked, moves_seen, step_now;
  longint left_goal, right_goal;

  int  tx_pct, rx_pct, sent;
  bit  rx_hold_go;
  longint pos_l, pos_r;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dual_motor_ratio_position_controller_core dut (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  dmrpc_checker chk (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fails, .pending, .words_checked, .moves_seen,
    .left_goal, .right_goal, .step_now
  );

  // receiver: random stall, plus one long hold-off on request
  initial begin
    int  hold_n;
    bit  held;
    hold_n = 0;
    held = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_go && !held) begin
        held = 1;
        hold_n = 600;
      end
      if (hold_n > 0) begin
        hold_n--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (rx_pct > 0) && ($urandom_range(0, 99) < rx_pct);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_tick(logic signed [31:0] l, logic signed [31:0] r);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word.left_dist  <= l;
    in_word.right_dist <= r;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(int m, int iv, int g, int b, int p);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(CFG_MARGIN, 16'(m));
    write_reg(CFG_INTERVAL, 16'(iv));
    write_reg(CFG_GAIN_DIV, 16'(g));
    write_reg(CFG_BASE_PWM, 16'(b));
    write_reg(CFG_PAUSE, 16'(p));
    cfg_valid <= 1'b0;
  endtask

  // move one wheel towards its goal by a random amount; near the goal, land on it or within 100 of it
  function automatic longint chase(longint pos, longint goal);
    longint d, s;
    d = goal - pos;
    if (d < 0) d = -d;
    if (d < 400) begin
      if ($urandom_range(0, 1)) return goal;
      return goal + $urandom_range(0, 200) - 100;
    end
    s = $urandom_range(0, 3000);
    if (s > d) s = d;
    return (goal > pos) ? pos + s : pos - s;
  endfunction

  task automatic run_ticks(int n);
    int k;
    repeat (n) begin
      k = $urandom_range(0, 99);
      if (k < 80) begin
        pos_l = chase(pos_l, left_goal);
        pos_r = chase(pos_r, right_goal);
        send_tick(32'(pos_l), 32'(pos_r));
      end else if (k < 90) begin
        send_tick(32'(pos_l), 32'(pos_r));
      end else if (k < 96) begin
        send_tick($urandom, $urandom);
      end else begin
        pos_l = pos_l + $urandom_range(0, 8000) - 4000;
        pos_r = pos_r + $urandom_range(0, 8000) - 4000;
        send_tick(32'(pos_l), 32'(pos_r));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MARGIN;
    cfg_data <= '0;
    tx_pct = 0;
    rx_pct = 0;
    rx_hold_go = 0;
    sent = 0;
    pos_l = 0;
    pos_r = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, one-sided errors, moves ending at once
    send_tick(32'sh7fffffff, 32'sh80000000);
    send_tick(0, 0);
    send_tick(32'sh80000000, 32'sh7fffffff);
    send_tick(-1, 1);
    send_tick(0, 0);
    send_tick(0, 100000);
    send_tick(0, 50000);
    send_tick(0, 0);
    send_tick(-100000, 0);
    send_tick(0, 0);
    send_tick(-100000, 100000);
    send_tick(-60000, 40000);
    send_tick(500, -500);
    send_tick(501, 0);
    send_tick(0, 0);
    send_tick(32'sh55555555, 32'shaaaaaaaa);
    send_tick(32'shaaaaaaaa, 32'sh55555555);
    send_tick(0, 0);
    run_ticks(160);

    set_regs(300, 1, 1, 1023, 0);
    tx_pct = 51;
    run_ticks(180);

    set_regs(0, 0, 0, 0, 1000);
    tx_pct = 0;
    rx_pct = 51;
    run_ticks(150);

    set_regs(65535, 1000, 255, 512, 5);
    tx_pct = 13;
    rx_pct = 13;
    run_ticks(150);

    set_regs(800, 7, 3, 700, 2);
    tx_pct = 0;
    rx_pct = 0;
    rx_hold_go = 1;
    run_ticks(200);

    repeat (3) begin
      set_regs($urandom_range(0, 2000), $urandom_range(0, 60), $urandom_range(0, 255),
               $urandom_range(0, 1023), $urandom_range(0, 30));
      tx_pct = $urandom_range(0, 1) ? 51 : 13;
      rx_pct = $urandom_range(0, 1) ? 51 : 13;
      run_ticks(190);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d ticks, checked %0d output words, %0d moves completed,",
             sent, words_checked, moves_seen);
    $display("table step %0d reached over 8 register settings.", step_now);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== dual_motor_ratio_position_controller_core.f =====
rtl/dmrpc_pkg.sv
rtl/dmrpc_div.sv
rtl/dual_motor_ratio_position_controller_core.sv
test/dmrpc_checker.sv
test/tb.sv
